// File: rtl/core/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg
// shared types for the indexed ordered list: request and result items,
// operation and status codes, and the per-cycle cell control group
// ----------------------------------------------------------------------------
package iol_pkg;

    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        KIND_INSERT    = 2'd0,
        KIND_REMOVE    = 2'd1,
        KIND_READ      = 2'd2,
        KIND_OVERWRITE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_POS = 2'd1,
        STATUS_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

    // control broadcast to every cell in the row
    typedef struct packed {
        logic             insert;
        logic             remove;
        logic             write;
        logic [POS_W-1:0] pos;
    } t_cell_ctrl;

endpackage

// File: rtl/core/indexed_ordered_list.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list
// ordered list of up to CAPACITY values with insert, remove, read and
// overwrite at a zero-based position, built as a row of shifting cells
// ----------------------------------------------------------------------------
// usage
//   input channel : i_in_valid / o_in_stall carry one request (kind,
//                   position, item_value); it is taken on a clock edge with
//                   valid high and stall low
//   output channel: o_out_valid / i_out_stall carry one result per request
//                   (read_value, status, entry_count)
//   timing        : the result is registered and shows in the cycle after the
//                   request is taken
//   throughput    : one request per cycle while the output is not stalled;
//                   every cell shifts, loads or holds in the same cycle, so
//                   the rate is set by the single decode-and-shift step
//                   between the count register and the cell row
//   stall         : while a result waits under i_out_stall, o_in_stall is
//                   raised and the list state holds; no result is dropped
//   reset         : i_rst_n low empties the list (count zero) and clears
//                   the output valid; cell contents are left as they are
//                   and are only read after being written
// ----------------------------------------------------------------------------
module indexed_ordered_list #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  iol_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output iol_pkg::t_out_item o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);

    // handshake
    logic fire;

    // request decode
    iol_pkg::t_cell_ctrl ctrl;
    iol_pkg::t_status    status;
    logic [CW-1:0]       next_count;

    // cell row
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [VALUE_WIDTH-1:0] wdata;
    logic [63:0]            wdata_wide;

    // read path
    logic [VALUE_WIDTH-1:0] rd_sel;
    logic [63:0]            rd_wide;
    logic [63:0]            count_wide;

    // result register
    logic               r_out_valid;
    logic               n_out_valid;
    iol_pkg::t_out_item r_out;
    iol_pkg::t_out_item n_out;

    // a waiting result blocks new requests only while it is stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign fire       = i_in_valid && !o_in_stall;

    iol_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_req       (i_in_item),
        .o_ctrl      (ctrl),
        .o_status    (status),
        .o_next_count(next_count)
    );

    // request value resized to the stored width
    assign wdata_wide = 64'(i_in_item.item_value);
    assign wdata      = wdata_wide[VALUE_WIDTH-1:0];

    // row of cells; the first cell never takes its zero left neighbor, the last takes its zero right one on remove
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left;
        logic [VALUE_WIDTH-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_value[g+1];
        end

        iol_cell #(
            .IDX        (g),
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (ctrl),
            .i_left (left),
            .i_right(right),
            .i_wdata(wdata),
            .o_value(cell_value[g])
        );
    end

    // read select: and-or over the row, one cell matches a valid position
    always_comb begin
        rd_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (k == int'(i_in_item.position)) begin
                rd_sel = rd_sel | cell_value[k];
            end
        end
    end

    assign rd_wide    = 64'(rd_sel);
    assign count_wide = 64'(next_count);

    always_comb begin
        n_out.read_value  = '0;
        n_out.status      = status;
        n_out.entry_count = count_wide[iol_pkg::COUNT_W-1:0];
        if ((i_in_item.kind == iol_pkg::KIND_READ) && (status == iol_pkg::STATUS_OK)) begin
            n_out.read_value = rd_wide[iol_pkg::VALUE_W-1:0];
        end
    end

    assign n_out_valid = fire || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload loads only with a new request, holds while stalled
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: rtl/core/iol_cell.sv
// ----------------------------------------------------------------------------
// iol_cell
// one list slot: holds, takes the left neighbor (insert), the right
// neighbor (remove) or the request value (insert or write at its own position)
// ----------------------------------------------------------------------------
module iol_cell #(
    parameter int IDX         = 0,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  iol_pkg::t_cell_ctrl    i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    input  logic [VALUE_WIDTH-1:0] i_wdata,
    output logic [VALUE_WIDTH-1:0] o_value
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic                   at_pos;
    logic                   above_pos;

    assign at_pos    = (IDX == int'(i_ctrl.pos));
    assign above_pos = (IDX > int'(i_ctrl.pos));

    always_comb begin
        n_value = r_value;
        if (i_ctrl.insert) begin
            if (above_pos) begin
                n_value = i_left;
            end else if (at_pos) begin
                n_value = i_wdata;
            end
        end else if (i_ctrl.remove) begin
            if (at_pos || above_pos) begin
                n_value = i_right;
            end
        end else if (i_ctrl.write && at_pos) begin
            n_value = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: rtl/core/iol_ctrl.sv
// ----------------------------------------------------------------------------
// iol_ctrl
// entry count and request decode: status check and cell control
// ----------------------------------------------------------------------------
module iol_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_fire,
    input  iol_pkg::t_in_item                  i_req,
    output iol_pkg::t_cell_ctrl                o_ctrl,
    output iol_pkg::t_status                   o_status,
    output logic [$clog2(CAPACITY+1)-1:0]      o_next_count
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > iol_pkg::POS_W) ? CW : iol_pkg::POS_W;

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            full;
    logic            ok;

    assign pos_ext = CMPW'(i_req.position);
    assign cnt_ext = CMPW'(r_count);
    assign full    = (r_count == CW'(CAPACITY));

    always_comb begin
        o_status = iol_pkg::STATUS_OK;
        unique case (i_req.kind)
            iol_pkg::KIND_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    o_status = iol_pkg::STATUS_BAD_POS;
                end else if (full) begin
                    o_status = iol_pkg::STATUS_FULL;
                end
            end
            default: begin
                if (pos_ext >= cnt_ext) begin
                    o_status = iol_pkg::STATUS_BAD_POS;
                end
            end
        endcase
    end

    assign ok = i_fire && (o_status == iol_pkg::STATUS_OK);

    always_comb begin
        o_ctrl.insert = ok && (i_req.kind == iol_pkg::KIND_INSERT);
        o_ctrl.remove = ok && (i_req.kind == iol_pkg::KIND_REMOVE);
        o_ctrl.write  = ok && (i_req.kind == iol_pkg::KIND_OVERWRITE);
        o_ctrl.pos    = i_req.position;
    end

    always_comb begin
        n_count = r_count;
        if (o_ctrl.insert) begin
            n_count = r_count + CW'(1);
        end else if (o_ctrl.remove) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_next_count = n_count;

endmodule

// File: tb/indexed_ordered_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_ordered_list_tb
// self-checking bench for the indexed ordered list: a shadow copy of the list
// predicts every result, a directed opening covers empty, single-entry and
// full cases, then random phases of mostly legal requests run under bursty
// input and patterned output stall
// ----------------------------------------------------------------------------
class list_scoreboard;
    localparam int DEPTH = 16;

    logic [iol_pkg::VALUE_W-1:0] shadow_cells [DEPTH];
    int unsigned                 shadow_count;
    iol_pkg::t_out_item          expected_q [$];
    int unsigned                 errors;

    function new();
        shadow_count = 0;
        errors       = 0;
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // apply one accepted request to the shadow list and queue its result
    function void note_request(iol_pkg::t_in_item req);
        iol_pkg::t_out_item res;
        int unsigned        pos;
        int unsigned        i;
        res.read_value = '0;
        res.status     = iol_pkg::STATUS_OK;
        pos            = 32'(req.position);
        if (req.kind == iol_pkg::KIND_INSERT) begin
            if (pos > shadow_count) begin
                res.status = iol_pkg::STATUS_BAD_POS;
            end else if (shadow_count >= DEPTH) begin
                res.status = iol_pkg::STATUS_FULL;
            end else begin
                for (i = shadow_count; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
                shadow_cells[pos] = req.item_value;
                shadow_count++;
            end
        end else if (pos >= shadow_count) begin
            res.status = iol_pkg::STATUS_BAD_POS;
        end else begin
            case (req.kind)
                iol_pkg::KIND_REMOVE: begin
                    for (i = pos; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
                    shadow_count--;
                end
                iol_pkg::KIND_READ: begin
                    res.read_value = shadow_cells[pos];
                end
                default: begin
                    shadow_cells[pos] = req.item_value;
                end
            endcase
        end
        res.entry_count = shadow_count[iol_pkg::COUNT_W-1:0];
        expected_q.push_back(res);
    endfunction

    task report_mismatch(string what, logic [iol_pkg::VALUE_W-1:0] got,
                         logic [iol_pkg::VALUE_W-1:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    task check_result(iol_pkg::t_out_item got);
        iol_pkg::t_out_item want;
        if (expected_q.size() == 0) begin
            report_mismatch("result with no request pending", got.read_value, '0);
        end else begin
            want = expected_q.pop_front();
            if (got.read_value !== want.read_value)
                report_mismatch("read_value", got.read_value, want.read_value);
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        end
    endtask
endclass

module indexed_ordered_list_tb;

    localparam int CAPACITY = 16;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    iol_pkg::t_in_item  i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    iol_pkg::t_out_item o_out_item;

    // raised once by the request driver to ask the stall process for a long hold-off
    logic      long_hold_go = 1'b0;

    list_scoreboard sb = new();

    indexed_ordered_list #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (iol_pkg::VALUE_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // result side: every accepted result is checked against the oldest prediction;
    // results show in the cycle after their request is taken, so the prediction is always queued first
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);
    end

    // offer one request and hold it until taken; called right after a rising edge
    task automatic send_request(input iol_pkg::t_kind kind,
                                input logic [iol_pkg::POS_W-1:0] pos,
                                input logic [iol_pkg::VALUE_W-1:0] value);
        iol_pkg::t_in_item req;
        req.kind       = kind;
        req.position   = pos;
        req.item_value = value;
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(req);
    endtask

    // drop valid for a number of cycles, with junk on the payload the block must ignore
    task automatic idle_cycles(input int n);
        logic [63:0] junk;
        if (n > 0) begin
            junk       = {$urandom, $urandom};
            i_in_valid <= 1'b0;
            i_in_item  <= junk[$bits(iol_pkg::t_in_item)-1:0];
            repeat (n) @(posedge i_clk);
        end
    endtask

    // sender pause until every predicted result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // one random phase; ins_pct and rem_pct steer the list toward full or empty,
    // the rest of the legal requests are reads and overwrites
    task automatic run_phase(input int n_items, input int ins_pct, input int rem_pct,
                             input int max_gap, input int max_burst);
        int                          burst_left;
        int                          cnt;
        int                          pick;
        iol_pkg::t_kind              kind;
        logic [iol_pkg::POS_W-1:0]   pos;
        logic [iol_pkg::VALUE_W-1:0] value;
        burst_left = $urandom_range(1, max_burst);
        repeat (n_items) begin
            if (burst_left == 0) begin
                idle_cycles($urandom_range(0, max_gap));
                burst_left = $urandom_range(1, max_burst);
            end
            burst_left--;
            case ($urandom_range(0, 7))
                0:       value = '0;
                1:       value = '1;
                2:       value = $urandom_range(0, 15);
                default: value = $urandom;
            endcase
            cnt  = sb.shadow_count;
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 12) begin
                // noise: any operation at any position the field can carry
                kind = iol_pkg::t_kind'($urandom_range(0, 3));
                pos  = iol_pkg::POS_W'($urandom_range(0, 31));
            end else if (cnt == 0 || pick < ins_pct) begin
                kind = iol_pkg::KIND_INSERT;
                case ($urandom_range(0, 3))
                    0:       pos = '0;
                    1:       pos = iol_pkg::POS_W'(cnt);
                    default: pos = iol_pkg::POS_W'($urandom_range(0, cnt));
                endcase
            end else begin
                if (pick < ins_pct + rem_pct) kind = iol_pkg::KIND_REMOVE;
                else if ($urandom_range(0, 1) == 0) kind = iol_pkg::KIND_READ;
                else kind = iol_pkg::KIND_OVERWRITE;
                case ($urandom_range(0, 3))
                    0:       pos = '0;
                    1:       pos = iol_pkg::POS_W'(cnt - 1);
                    default: pos = iol_pkg::POS_W'($urandom_range(0, cnt - 1));
                endcase
            end
            send_request(kind, pos, value);
        end
    endtask

    // output stall: segments of no stall, light stall, heavy stall and toggling,
    // plus one long hold-off on request so the block backs up into its input
    initial begin
        int   mode;
        int   seg_len;
        logic stall_now;
        logic held;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_go && !held) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(8, 64);
            repeat (seg_len) begin
                case (mode)
                    0:       stall_now = 1'b0;
                    1:       stall_now = ($urandom_range(0, 3) == 0);
                    2:       stall_now = ($urandom_range(0, 3) != 0);
                    default: stall_now = ~i_out_stall;
                endcase
                i_out_stall <= stall_now;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: remove finds nothing, insert far past the end is refused
        send_request(iol_pkg::KIND_REMOVE, 5'd0, $urandom);
        send_request(iol_pkg::KIND_INSERT, 5'd31, '1);
        // single entry: read it back, overwrite it, then remove it
        send_request(iol_pkg::KIND_INSERT, 5'd0, '1);
        send_request(iol_pkg::KIND_READ, 5'd0, $urandom);
        send_request(iol_pkg::KIND_OVERWRITE, 5'd0, '0);
        send_request(iol_pkg::KIND_REMOVE, 5'd0, $urandom);
        // fill to capacity, alternating insert at the end and at the beginning
        for (k = 0; k < CAPACITY; k++) begin
            if (k % 2 == 0) send_request(iol_pkg::KIND_INSERT, iol_pkg::POS_W'(k), $urandom);
            else send_request(iol_pkg::KIND_INSERT, 5'd0, $urandom);
        end
        // full list: legal position reports full, past the end reports bad position
        send_request(iol_pkg::KIND_INSERT, 5'd16, $urandom);
        send_request(iol_pkg::KIND_INSERT, 5'd17, $urandom);
        send_request(iol_pkg::KIND_READ, 5'd16, $urandom);
        drain_results();

        run_phase(400, 35, 35, 3, 8);
        drain_results();
        // back-to-back requests while the output is held off for a long stretch
        long_hold_go = 1'b1;
        run_phase(400, 60, 10, 0, 20);
        drain_results();
        run_phase(400, 15, 60, 4, 4);
        drain_results();
        run_phase(375, 40, 30, 1, 30);
        drain_results();
        run_phase(350, 50, 20, 6, 3);
        drain_results();

        // a few more cycles to catch any stray result
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("indexed_ordered_list_tb OK");
        end else begin
            $display("indexed_ordered_list_tb NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("indexed_ordered_list_tb NOT OK");
        $finish;
    end

endmodule
